FILE: src/etgsa_pkg.sv
package etgsa_pkg;

  // action codes carried in the low bits of the input item
  localparam logic [2:0] ACT_WRITE_W = 3'd0;
  localparam logic [2:0] ACT_LOOKUP  = 3'd1;
  localparam logic [2:0] ACT_CLEAR   = 3'd2;
  localparam logic [2:0] ACT_ACCUM   = 3'd3;
  localparam logic [2:0] ACT_READ_G  = 3'd4;
  localparam logic [2:0] ACT_READ_W  = 3'd5;

  localparam int ACT_W   = 3;
  localparam int TOK_W   = 10;
  localparam int ELEM_W  = 6;
  localparam int VALUE_W = 32;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic [VALUE_W-1:0] data_value;
    logic [ELEM_W-1:0]  element_index;
    logic [TOK_W-1:0]   token_index;
    logic [ACT_W-1:0]   action;
  } in_item_t;

endpackage

FILE: src/etgsa_ram.sv
module etgsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/embedding_table_gather_scatter_add.sv
// Channel  Direction  Signals                      Content
// s        in         s_tvalid s_tready s_tdata    one action item
// m        out        m_tvalid m_tready m_tdata    one table element
//                     m_tlast                      last of row / single read
//
// Write weight is done on accept; read weight or gradient runs an address then a data state;
// accumulate runs the same two states, and an untouched row is zeroed (one gradient RAM write
// a cycle zeroes it) before the add is retried. Lookup runs an address and a data state per
// element: each element is one RAM read and one output load. Clear gradients and reset both
// run a pass over every row of the row valid-bit RAM; s_tready stays low meanwhile. A stalled
// m side holds the sequencer in its output state; s_tready is high only when idle.
module embedding_table_gather_scatter_add #(
  parameter int VOCAB     = 1024,
  parameter int ROW_ELEMS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // action[2:0], token_index[12:3], element_index[18:13], data_value[50:19]
  input  logic [etgsa_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // result_value[31:0], result_element[37:32]
  output logic [etgsa_pkg::OUT_DATA_W-1:0]  m_tdata,
  // last_of_row
  output logic                              m_tlast
);

  localparam int AW = $clog2(VOCAB * ROW_ELEMS);
  localparam int RW = $clog2(VOCAB);
  localparam int EW = (ROW_ELEMS > 1) ? $clog2(ROW_ELEMS) : 1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LK_ADDR, ST_LK_DATA, ST_RD_ADDR, ST_RD_DATA,
    ST_AC_ADDR, ST_AC_DATA, ST_ZERO
  } state_t;

  function automatic logic [AW-1:0] elem_addr(input logic [etgsa_pkg::TOK_W-1:0] tok,
                                              input logic [EW-1:0] e);
    elem_addr = AW'(AW'(tok) * AW'(ROW_ELEMS)) + AW'(e);
  endfunction

  state_t state;

  etgsa_pkg::in_item_t in_item;

  logic [etgsa_pkg::ACT_W-1:0]   item_act;
  logic [etgsa_pkg::TOK_W-1:0]   item_tok;
  logic [etgsa_pkg::ELEM_W-1:0]  item_el;
  logic [etgsa_pkg::VALUE_W-1:0] item_data;
  logic                          item_ok;
  logic                          tok_ok;
  logic [EW-1:0]                 elem_cnt;
  logic [RW-1:0]                 row_cnt;

  logic in_tok_ok;
  logic in_el_ok;
  logic accept;
  logic out_free;
  logic out_load;

  logic          w_wr_en;
  logic [AW-1:0] w_wr_addr;
  logic [AW-1:0] w_rd_addr;
  logic [31:0]   w_rd_data;

  logic          g_wr_en;
  logic [AW-1:0] g_wr_addr;
  logic [31:0]   g_wr_data;
  logic [AW-1:0] g_rd_addr;
  logic [31:0]   g_rd_data;

  logic          t_wr_en;
  logic [RW-1:0] t_wr_addr;
  logic [0:0]    t_wr_data;
  logic [RW-1:0] t_rd_addr;
  logic [0:0]    t_rd_data;

  logic signed [32:0] grad_sum;
  logic [31:0]        grad_sat;
  logic [31:0]        read_value;

  assign in_item   = etgsa_pkg::in_item_t'(s_tdata[50:0]);
  assign in_tok_ok = 32'(in_item.token_index) < VOCAB;
  assign in_el_ok  = 32'(in_item.element_index) < ROW_ELEMS;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free && (state == ST_LK_DATA || state == ST_RD_DATA);

  // weights are written straight from the accepted item
  assign w_wr_en   = accept && (in_item.action == etgsa_pkg::ACT_WRITE_W)
                     && in_tok_ok && in_el_ok;
  assign w_wr_addr = elem_addr(in_item.token_index, EW'(in_item.element_index));
  assign w_rd_addr = (state == ST_LK_ADDR || state == ST_LK_DATA)
                     ? elem_addr(item_tok, elem_cnt)
                     : elem_addr(item_tok, EW'(item_el));

  assign g_rd_addr = elem_addr(item_tok, EW'(item_el));
  assign t_rd_addr = RW'(item_tok);

  assign grad_sum = {g_rd_data[31], g_rd_data} + {item_data[31], item_data};

  always_comb begin
    if (grad_sum[32] != grad_sum[31]) begin
      grad_sat = grad_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      grad_sat = grad_sum[31:0];
    end
  end

  always_comb begin
    if (!item_ok) begin
      read_value = '0;
    end else if (item_act == etgsa_pkg::ACT_READ_G) begin
      read_value = t_rd_data[0] ? g_rd_data : '0;
    end else begin
      read_value = w_rd_data;
    end
  end

  always_comb begin
    g_wr_en   = 1'b0;
    g_wr_addr = elem_addr(item_tok, EW'(item_el));
    g_wr_data = grad_sat;
    t_wr_en   = 1'b0;
    t_wr_addr = row_cnt;
    t_wr_data = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        t_wr_en = 1'b1;
      end
      ST_ZERO: begin
        g_wr_en   = 1'b1;
        g_wr_addr = elem_addr(item_tok, elem_cnt);
        g_wr_data = '0;
        // mark the row once its last element is zeroed
        if (elem_cnt == EW'(ROW_ELEMS - 1)) begin
          t_wr_en   = 1'b1;
          t_wr_addr = RW'(item_tok);
          t_wr_data = 1'b1;
        end
      end
      ST_AC_DATA: begin
        g_wr_en = t_rd_data[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      row_cnt  <= '0;
      elem_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          row_cnt <= row_cnt + 1'b1;
          if (row_cnt == RW'(VOCAB - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            item_act  <= in_item.action;
            item_tok  <= in_item.token_index;
            item_el   <= in_item.element_index;
            item_data <= in_item.data_value;
            item_ok   <= in_tok_ok && in_el_ok;
            tok_ok    <= in_tok_ok;
            elem_cnt  <= '0;
            row_cnt   <= '0;
            unique case (in_item.action) inside
              etgsa_pkg::ACT_LOOKUP: state <= ST_LK_ADDR;
              etgsa_pkg::ACT_CLEAR:  state <= ST_CLEAR;
              etgsa_pkg::ACT_ACCUM: begin
                if (in_tok_ok && in_el_ok) begin
                  state <= ST_AC_ADDR;
                end
              end
              etgsa_pkg::ACT_READ_G, etgsa_pkg::ACT_READ_W: state <= ST_RD_ADDR;
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_LK_ADDR: begin
          state <= ST_LK_DATA;
        end
        ST_LK_DATA: begin
          if (out_free) begin
            m_tvalid        <= 1'b1;
            m_tdata[31:0]   <= tok_ok ? w_rd_data : '0;
            m_tdata[37:32]  <= etgsa_pkg::ELEM_W'(elem_cnt);
            m_tdata[39:38]  <= '0;
            m_tlast         <= (elem_cnt == EW'(ROW_ELEMS - 1));
            elem_cnt        <= elem_cnt + 1'b1;
            state           <= (elem_cnt == EW'(ROW_ELEMS - 1)) ? ST_IDLE : ST_LK_ADDR;
          end
        end
        ST_RD_ADDR: begin
          state <= ST_RD_DATA;
        end
        ST_RD_DATA: begin
          if (out_free) begin
            m_tvalid       <= 1'b1;
            m_tdata[31:0]  <= read_value;
            m_tdata[37:32] <= item_el;
            m_tdata[39:38] <= '0;
            m_tlast        <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        ST_AC_ADDR: begin
          state <= ST_AC_DATA;
        end
        ST_AC_DATA: begin
          // an untouched row is zeroed first, then the add is retried
          state <= t_rd_data[0] ? ST_IDLE : ST_ZERO;
        end
        ST_ZERO: begin
          elem_cnt <= elem_cnt + 1'b1;
          if (elem_cnt == EW'(ROW_ELEMS - 1)) begin
            state <= ST_AC_ADDR;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  etgsa_ram #(.WIDTH(32), .DEPTH(VOCAB * ROW_ELEMS)) u_weight_ram (
    .clk     (clk),
    .wr_en   (w_wr_en),
    .wr_addr (w_wr_addr),
    .wr_data (in_item.data_value),
    .rd_addr (w_rd_addr),
    .rd_data (w_rd_data)
  );

  etgsa_ram #(.WIDTH(32), .DEPTH(VOCAB * ROW_ELEMS)) u_grad_ram (
    .clk     (clk),
    .wr_en   (g_wr_en),
    .wr_addr (g_wr_addr),
    .wr_data (g_wr_data),
    .rd_addr (g_rd_addr),
    .rd_data (g_rd_data)
  );

  etgsa_ram #(.WIDTH(1), .DEPTH(VOCAB)) u_touched_ram (
    .clk     (clk),
    .wr_en   (t_wr_en),
    .wr_addr (t_wr_addr),
    .wr_data (t_wr_data),
    .rd_addr (t_rd_addr),
    .rd_data (t_rd_data)
  );

endmodule

FILE: src/etgsa_checker.sv
module etgsa_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [etgsa_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [etgsa_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                             m_tlast
);

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // a lookup keeps the input side closed while its row streams
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[2:0] == etgsa_pkg::ACT_LOOKUP) |=> !s_tready)
    else $error("item accepted during lookup");

  // a weight write finishes in its accept cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[2:0] == etgsa_pkg::ACT_WRITE_W) |=> s_tready)
    else $error("weight write stalled input");

  // mid-row results only come while a lookup is still running
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |-> !s_tready)
    else $error("row result outside lookup");

endmodule

bind embedding_table_gather_scatter_add etgsa_checker u_etgsa_checker (.*);

FILE: bench/tb_embedding_table_gather_scatter_add.sv
module tb_embedding_table_gather_scatter_add;

  localparam int N_ROWS = 1024;
  localparam int ROW_LEN = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [etgsa_pkg::ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [etgsa_pkg::ACT_W-1:0] ACT_SPARE_HI = 3'd7;
  localparam logic [etgsa_pkg::VALUE_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [etgsa_pkg::VALUE_W-1:0] Q_MIN = 32'h8000_0000;

  typedef struct {
    logic [etgsa_pkg::VALUE_W-1:0] value;
    logic [etgsa_pkg::ELEM_W-1:0]  element;
    logic                          last;
  } table_elem_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [etgsa_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [etgsa_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                             m_tlast;

  always #1 clk = ~clk;

  embedding_table_gather_scatter_add #(
    .VOCAB     (N_ROWS),
    .ROW_ELEMS (ROW_LEN)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // shadow tables, keyed by row * ROW_LEN + element
  logic [etgsa_pkg::VALUE_W-1:0] weight_mem [int];
  logic [etgsa_pkg::VALUE_W-1:0] grad_mem [int];
  bit                            grad_row_live [N_ROWS];
  bit [ROW_LEN-1:0]              weight_written [N_ROWS];
  int                            written_weights [$];
  int                            full_rows [$];
  table_elem_t                   expected_elems [$];

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_count = 0;
  int items_sent = 0;
  int elems_checked = 0;
  int lookups_sent = 0;
  int saturations = 0;

  function automatic void flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic logic [etgsa_pkg::VALUE_W-1:0] stored_weight(input int row, input int el);
    if (row >= N_ROWS || el >= ROW_LEN || !weight_mem.exists(row * ROW_LEN + el)) return '0;
    return weight_mem[row * ROW_LEN + el];
  endfunction

  function automatic void apply_table_action(input etgsa_pkg::in_item_t it);
    int          row;
    int          el;
    int          key;
    bit          in_range;
    longint      sum;
    table_elem_t e;
    row = int'(it.token_index);
    el = int'(it.element_index);
    key = row * ROW_LEN + el;
    in_range = row < N_ROWS && el < ROW_LEN;
    case (it.action)
      etgsa_pkg::ACT_WRITE_W: if (in_range) begin
        weight_mem[key] = it.data_value;
        if (!weight_written[row][el]) begin
          weight_written[row][el] = 1'b1;
          written_weights.push_back(key);
          if (&weight_written[row]) full_rows.push_back(row);
        end
      end
      etgsa_pkg::ACT_LOOKUP: for (int k = 0; k < ROW_LEN; k++) begin
        e.value = stored_weight(row, k);
        e.element = etgsa_pkg::ELEM_W'(k);
        e.last = (k == ROW_LEN - 1);
        expected_elems.push_back(e);
      end
      etgsa_pkg::ACT_CLEAR: foreach (grad_row_live[i]) grad_row_live[i] = 1'b0;
      etgsa_pkg::ACT_ACCUM: if (in_range) begin
        // first touch since a clear zeroes the whole row
        if (!grad_row_live[row]) begin
          for (int k = 0; k < ROW_LEN; k++) grad_mem[row * ROW_LEN + k] = '0;
          grad_row_live[row] = 1'b1;
        end
        sum = longint'($signed(grad_mem[key])) + longint'($signed(it.data_value));
        if (sum > longint'(Q_MAX)) begin
          sum = longint'(Q_MAX);
          saturations++;
        end else if (sum < -longint'(Q_MIN)) begin
          sum = -longint'(Q_MIN);
          saturations++;
        end
        grad_mem[key] = sum[etgsa_pkg::VALUE_W-1:0];
      end
      etgsa_pkg::ACT_READ_G: begin
        e.value = (in_range && grad_row_live[row]) ? grad_mem[key] : '0;
        e.element = it.element_index;
        e.last = 1'b1;
        expected_elems.push_back(e);
      end
      etgsa_pkg::ACT_READ_W: begin
        e.value = stored_weight(row, el);
        e.element = it.element_index;
        e.last = 1'b1;
        expected_elems.push_back(e);
      end
      default: ;
    endcase
  endfunction

  function automatic etgsa_pkg::in_item_t make_item(input logic [etgsa_pkg::ACT_W-1:0] act,
                                                    input int row, input int el,
                                                    input logic [etgsa_pkg::VALUE_W-1:0] val);
    etgsa_pkg::in_item_t it;
    it.action = act;
    it.token_index = etgsa_pkg::TOK_W'(row);
    it.element_index = etgsa_pkg::ELEM_W'(el);
    it.data_value = val;
    return it;
  endfunction

  function automatic logic [etgsa_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return '1;
      4: return etgsa_pkg::VALUE_W'(int'($urandom_range(511)) - 256);
      default: return $urandom;
    endcase
  endfunction

  // a few rows take most of the gradients so that sums grow into saturation
  function automatic int pick_grad_row();
    if ($urandom_range(99) >= 60) return $urandom_range(N_ROWS - 1);
    case ($urandom_range(3))
      0: return 3;
      1: return 517;
      2: return 1022;
      default: return 64;
    endcase
  endfunction

  function automatic int pick_grad_elem();
    if ($urandom_range(1) == 0) return $urandom_range(1);
    return $urandom_range(ROW_LEN - 1);
  endfunction

  task automatic send_item(input etgsa_pkg::in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= etgsa_pkg::IN_DATA_W'(it);
    apply_table_action(it);
    items_sent++;
    if (it.action == etgsa_pkg::ACT_LOOKUP) lookups_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_elems.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic fill_row(input int row);
    for (int k = 0; k < ROW_LEN; k++) begin
      send_item(make_item(etgsa_pkg::ACT_WRITE_W, row, k, pick_value()));
    end
  endtask

  task automatic test_weight_extremes();
    send_item(make_item(etgsa_pkg::ACT_WRITE_W, N_ROWS - 1, 0, Q_MIN));
    send_item(make_item(etgsa_pkg::ACT_WRITE_W, N_ROWS - 1, ROW_LEN - 1, Q_MAX));
    send_item(make_item(etgsa_pkg::ACT_WRITE_W, 0, 0, '0));
    send_item(make_item(etgsa_pkg::ACT_WRITE_W, 0, ROW_LEN - 1, '1));
    send_item(make_item(etgsa_pkg::ACT_LOOKUP, 0, $urandom_range(ROW_LEN - 1), $urandom));
    send_item(make_item(etgsa_pkg::ACT_LOOKUP, N_ROWS - 1, $urandom_range(ROW_LEN - 1),
                        $urandom));
    send_item(make_item(etgsa_pkg::ACT_READ_W, N_ROWS - 1, 0, $urandom));
    send_item(make_item(etgsa_pkg::ACT_READ_W, N_ROWS - 1, ROW_LEN - 1, $urandom));
    send_item(make_item(etgsa_pkg::ACT_READ_W, 0, 0, $urandom));
  endtask

  task automatic test_gradient_saturation();
    send_item(make_item(etgsa_pkg::ACT_READ_G, 5, 7, $urandom));
    send_item(make_item(etgsa_pkg::ACT_ACCUM, 5, 7, 32'h7FFF_FFF0));
    send_item(make_item(etgsa_pkg::ACT_ACCUM, 5, 7, 32'h0000_0100));
    send_item(make_item(etgsa_pkg::ACT_READ_G, 5, 7, $urandom));
    send_item(make_item(etgsa_pkg::ACT_READ_G, 5, 8, $urandom));
    send_item(make_item(etgsa_pkg::ACT_ACCUM, 6, 0, Q_MIN));
    send_item(make_item(etgsa_pkg::ACT_ACCUM, 6, 0, '1));
    send_item(make_item(etgsa_pkg::ACT_READ_G, 6, 0, $urandom));
  endtask

  task automatic test_gradient_clear();
    send_item(make_item(etgsa_pkg::ACT_CLEAR, $urandom_range(N_ROWS - 1),
                        $urandom_range(ROW_LEN - 1), $urandom));
    send_item(make_item(etgsa_pkg::ACT_READ_G, 5, 7, $urandom));
    send_item(make_item(etgsa_pkg::ACT_ACCUM, 5, 8, 32'd3));
    send_item(make_item(etgsa_pkg::ACT_READ_G, 5, 7, $urandom));
    send_item(make_item(etgsa_pkg::ACT_READ_G, 5, 8, $urandom));
  endtask

  task automatic test_unused_actions();
    send_item(make_item(ACT_SPARE_LO, $urandom_range(N_ROWS - 1), $urandom_range(ROW_LEN - 1),
                        $urandom));
    send_item(make_item(ACT_SPARE_HI, $urandom_range(N_ROWS - 1), $urandom_range(ROW_LEN - 1),
                        $urandom));
  endtask

  // receiver stops while lookups keep coming, so the input side must stall
  task automatic test_backpressure();
    int saved_idle;
    saved_idle = src_idle_pct;
    src_idle_pct = 0;
    hold_req++;
    repeat (3) begin
      send_item(make_item(etgsa_pkg::ACT_LOOKUP,
                          full_rows[$urandom_range(full_rows.size() - 1)],
                          $urandom_range(ROW_LEN - 1), $urandom));
    end
    send_item(make_item(etgsa_pkg::ACT_READ_G, 5, 8, $urandom));
    src_idle_pct = saved_idle;
    wait_idle();
  endtask

  task automatic test_random(input int n);
    int pick;
    int row;
    int key;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        row = ($urandom_range(1) == 0) ? full_rows[$urandom_range(full_rows.size() - 1)]
                                       : $urandom_range(N_ROWS - 1);
        send_item(make_item(etgsa_pkg::ACT_WRITE_W, row, $urandom_range(ROW_LEN - 1),
                            pick_value()));
      end else if (pick < 36) begin
        send_item(make_item(etgsa_pkg::ACT_LOOKUP,
                            full_rows[$urandom_range(full_rows.size() - 1)],
                            $urandom_range(ROW_LEN - 1), $urandom));
      end else if (pick < 48) begin
        key = written_weights[$urandom_range(written_weights.size() - 1)];
        send_item(make_item(etgsa_pkg::ACT_READ_W, key / ROW_LEN, key % ROW_LEN, $urandom));
      end else if (pick < 72) begin
        send_item(make_item(etgsa_pkg::ACT_ACCUM, pick_grad_row(), pick_grad_elem(),
                            pick_value()));
      end else if (pick < 92) begin
        send_item(make_item(etgsa_pkg::ACT_READ_G, pick_grad_row(), pick_grad_elem(),
                            $urandom));
      end else if (pick < 95) begin
        send_item(make_item(etgsa_pkg::ACT_CLEAR, $urandom_range(N_ROWS - 1),
                            $urandom_range(ROW_LEN - 1), $urandom));
      end else if (pick < 98) begin
        send_item(make_item($urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO,
                            $urandom_range(N_ROWS - 1), $urandom_range(ROW_LEN - 1),
                            $urandom));
      end else begin
        send_item(make_item(etgsa_pkg::ACT_ACCUM, $urandom_range(N_ROWS - 1),
                            $urandom_range(ROW_LEN - 1), pick_value()));
      end
    end
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    table_elem_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_elems.size() == 0) begin
        flag_error($sformatf("unexpected item: value %h element %0d last %b",
                             m_tdata[31:0], m_tdata[37:32], m_tlast));
      end else begin
        want = expected_elems.pop_front();
        elems_checked++;
        if (m_tdata[31:0] !== want.value || m_tdata[37:32] !== want.element ||
            m_tlast !== want.last) begin
          flag_error($sformatf("expected value %h element %0d last %b, got %h %0d %b",
                               want.value, want.element, want.last,
                               m_tdata[31:0], m_tdata[37:32], m_tlast));
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 35;
    sink_idle_pct = 85;
    fill_row(0);
    fill_row(N_ROWS - 1);
    test_weight_extremes();
    test_gradient_saturation();
    test_gradient_clear();
    test_unused_actions();
    wait_idle();
    test_backpressure();
    test_random(70);

    src_idle_pct = 85;
    sink_idle_pct = 35;
    test_random(70);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random(55);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items (%0d row lookups); checked %0d table elements; %0d clamped sums",
             items_sent, lookups_sent, elems_checked, saturations);
    $display("Idle mixes 35/85, 85/35 and 0/0 percent, plus one %0d-cycle receiver hold",
             HOLD_CYCLES);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", err_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout: %0d table elements still expected", expected_elems.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
